// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked checks, disabled in reset
`define EOFM_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("eofm check failed");

`define EOFM_ASSERT_IMP(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("eofm check failed");

`define EOFM_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("eofm check failed");

`endif

// ===== design/eofm_pkg.sv =====
package eofm_pkg;

  localparam int NSQ    = 96;
  localparam int NDV    = 31;
  localparam int NFRONT = 12;
  localparam int NSTG   = NFRONT + NSQ + NDV + 1;

  localparam int MAG_W  = 96;
  localparam int RAD_W  = 2 * NSQ;
  localparam int ROOT_W = NSQ;
  localparam int REM_W  = NSQ + 2;
  localparam int Q_W    = NDV;
  localparam int DR_W   = MAG_W + NDV - 1;

  localparam logic [31:0]        ONE_Q30   = 32'h4000_0000;
  localparam logic signed [31:0] ONE_Q30_S = 32'sh4000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_POS = 2'd1,
    ST_ZERO_MOM = 2'd2,
    ST_ZERO_X   = 2'd3
  } status_t;

  typedef struct packed {
    logic [8:0][MAG_W-1:0] mag;
    logic [8:0]            neg;
    status_t               stat;
  } elem_t;

endpackage

// ===== design/eofm_req_if.sv =====
interface eofm_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// ===== design/eofm_rsp_if.sv =====
interface eofm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  logic [1:0]         status;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, status,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, status,
                output ready);
endinterface

// ===== design/eci_to_orbit_frame_matrix.sv =====
// Throughput: one beat per cycle; 12 front stages (cross products, squares),
// 96 square-root stages (one root bit each), 31 divide stages, one output stage.
// The whole pipe holds when the output beat is stalled.
// Reset (synchronous) clears only the stage valid bits.
module eci_to_orbit_frame_matrix
  import eofm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  eofm_req_if.sink    req,
  eofm_rsp_if.source  rsp
);

  typedef struct packed {
    logic [2:0][31:0] pa;
    logic [2:0]       pn;
    logic [2:0][63:0] ha;
    logic [2:0]       hn;
    logic             zp;
    logic             zh;
    logic [63:0]      sz;
  } ctx_t;

  typedef struct packed {
    elem_t        el;
    logic [63:0]  sz;
    logic [127:0] sy;
  } tl_t;

  localparam int A_IDX [3] = '{1, 2, 0};
  localparam int B_IDX [3] = '{2, 0, 1};

  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv       = !vld[NSTG-1] || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], req.valid};
    end
  end

  logic signed [31:0]  p1 [3];
  logic signed [31:0]  v1 [3];
  logic signed [31:0]  p2 [3];
  logic signed [63:0]  pv2 [6];
  logic signed [63:0]  pq2 [3];
  logic signed [31:0]  p3 [3];
  logic signed [64:0]  h3 [3];
  logic [63:0]         sz3;
  ctx_t                c4, c5, c6, c7;
  logic [63:0]         xm5 [3][2][2];
  logic [63:0]         hq5 [3][3];
  logic [95:0]         xt6 [3][2];
  logic [127:0]        hs6 [3];
  logic signed [96:0]  x7 [3];
  logic [127:0]        sy7;
  logic                zx7;
  status_t             st7;
  tl_t                 t8, t9, t10, t11, t12;
  logic [63:0]         xq9 [3][3][3];
  logic [127:0]        xr10 [3][3];
  logic [191:0]        xs11 [3];
  logic [191:0]        sx12;

  assign zx7 = (x7[0] == '0) && (x7[1] == '0) && (x7[2] == '0);

  always_comb begin
    if (c7.zp) begin
      st7 = ST_ZERO_POS;
    end else if (c7.zh) begin
      st7 = ST_ZERO_MOM;
    end else if (zx7) begin
      st7 = ST_ZERO_X;
    end else begin
      st7 = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1[0] <= req.pos_x;
      p1[1] <= req.pos_y;
      p1[2] <= req.pos_z;
      v1[0] <= req.vel_x;
      v1[1] <= req.vel_y;
      v1[2] <= req.vel_z;
      for (int i = 0; i < 3; i++) begin
        // products for H = P x V and |P|^2
        pv2[2*i]   <= p1[A_IDX[i]] * v1[B_IDX[i]];
        pv2[2*i+1] <= p1[B_IDX[i]] * v1[A_IDX[i]];
        pq2[i]     <= p1[i] * p1[i];
        p2[i]      <= p1[i];

        h3[i] <= 65'(pv2[2*i]) - 65'(pv2[2*i+1]);
        p3[i] <= p2[i];

        c4.ha[i] <= h3[i][64] ? 64'(-h3[i]) : 64'(h3[i]);
        c4.hn[i] <= h3[i][64];
        c4.pa[i] <= p3[i][31] ? 32'(-p3[i]) : 32'(p3[i]);
        c4.pn[i] <= p3[i][31];

        // X = H x P as magnitude partial products; |H|^2 partials
        xm5[i][0][0] <= 64'(c4.ha[A_IDX[i]][31:0])  * 64'(c4.pa[B_IDX[i]]);
        xm5[i][0][1] <= 64'(c4.ha[A_IDX[i]][63:32]) * 64'(c4.pa[B_IDX[i]]);
        xm5[i][1][0] <= 64'(c4.ha[B_IDX[i]][31:0])  * 64'(c4.pa[A_IDX[i]]);
        xm5[i][1][1] <= 64'(c4.ha[B_IDX[i]][63:32]) * 64'(c4.pa[A_IDX[i]]);
        hq5[i][0] <= 64'(c4.ha[i][31:0])  * 64'(c4.ha[i][31:0]);
        hq5[i][1] <= 64'(c4.ha[i][31:0])  * 64'(c4.ha[i][63:32]);
        hq5[i][2] <= 64'(c4.ha[i][63:32]) * 64'(c4.ha[i][63:32]);

        for (int t = 0; t < 2; t++) begin
          xt6[i][t] <= 96'(xm5[i][t][0]) + (96'(xm5[i][t][1]) << 32);
        end
        hs6[i] <= 128'(hq5[i][0]) + (128'(hq5[i][1]) << 33) + (128'(hq5[i][2]) << 64);

        x7[i] <= ((c6.hn[A_IDX[i]] ^ c6.pn[B_IDX[i]]) ? -$signed({1'b0, xt6[i][0]})
                                                      :  $signed({1'b0, xt6[i][0]}))
               - ((c6.hn[B_IDX[i]] ^ c6.pn[A_IDX[i]]) ? -$signed({1'b0, xt6[i][1]})
                                                      :  $signed({1'b0, xt6[i][1]}));

        t8.el.mag[i]   <= x7[i][96] ? 96'(-x7[i]) : 96'(x7[i]);
        t8.el.mag[3+i] <= 96'(c7.ha[i]);
        t8.el.mag[6+i] <= 96'(c7.pa[i]);
        t8.el.neg[i]   <= x7[i][96];
        t8.el.neg[3+i] <= !c7.hn[i];
        t8.el.neg[6+i] <= !c7.pn[i];

        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            xq9[i][a][b] <= 64'(t8.el.mag[i][32*a +: 32]) * 64'(t8.el.mag[i][32*b +: 32]);
          end
          xr10[i][a] <= 128'(xq9[i][a][0]) + (128'(xq9[i][a][1]) << 32)
                      + (128'(xq9[i][a][2]) << 64);
        end
        xs11[i] <= 192'(xr10[i][0]) + (192'(xr10[i][1]) << 32) + (192'(xr10[i][2]) << 64);
      end

      sz3   <= 64'(pq2[0]) + 64'(pq2[1]) + 64'(pq2[2]);
      c4.sz <= sz3;
      c4.zp <= (sz3 == '0);
      c4.zh <= (h3[0] == '0) && (h3[1] == '0) && (h3[2] == '0);
      c5    <= c4;
      c6    <= c5;
      c7    <= c6;
      sy7   <= hs6[0] + hs6[1] + hs6[2];

      t8.el.stat <= st7;
      t8.sz      <= c7.sz;
      t8.sy      <= sy7;
      t9         <= t8;
      t10        <= t9;
      t11        <= t10;
      t12        <= t11;
      sx12       <= xs11[0] + xs11[1] + xs11[2];
    end
  end

  // square root, lanes: 0 position, 1 momentum, 2 X vector
  logic [RAD_W-1:0]  qrad  [NSQ+1][3];
  logic [REM_W-1:0]  qrem  [NSQ+1][3];
  logic [ROOT_W-1:0] qroot [NSQ+1][3];
  elem_t             qel   [NSQ+1];

  assign qrad[0][0] = RAD_W'(t12.sz);
  assign qrad[0][1] = RAD_W'(t12.sy);
  assign qrad[0][2] = sx12;
  assign qel[0]     = t12.el;

  genvar k, l, j, e;
  for (l = 0; l < 3; l++) begin : g_sq0
    assign qrem[0][l]  = '0;
    assign qroot[0][l] = '0;
  end

  for (k = 0; k < NSQ; k++) begin : g_sq
    for (l = 0; l < 3; l++) begin : g_ln
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] tr;
      logic             ge;
      assign r2 = {qrem[k][l], qrad[k][l][RAD_W-1 -: 2]};
      assign tr = {2'b00, qroot[k][l], 2'b01};
      assign ge = (r2 >= tr);
      always_ff @(posedge clk) begin
        if (adv) begin
          qrad[k+1][l]  <= qrad[k][l] << 2;
          qrem[k+1][l]  <= ge ? REM_W'(r2 - tr) : REM_W'(r2);
          qroot[k+1][l] <= {qroot[k][l][ROOT_W-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        qel[k+1] <= qel[k];
      end
    end
  end

  // restoring divide, one quotient bit per stage
  logic [DR_W-1:0]   dr    [NDV+1][9];
  logic [Q_W-1:0]    dq    [NDV+1][9];
  logic [ROOT_W-1:0] droot [NDV+1][3];
  logic [8:0]        dneg  [NDV+1];
  status_t           dst   [NDV+1];

  for (l = 0; l < 3; l++) begin : g_dv0r
    assign droot[0][l] = qroot[NSQ][l];
  end
  for (e = 0; e < 9; e++) begin : g_dv0e
    assign dr[0][e] = {qel[NSQ].mag[e], (NDV-1)'(0)};
    assign dq[0][e] = '0;
  end
  assign dneg[0] = qel[NSQ].neg;
  assign dst[0]  = qel[NSQ].stat;

  for (j = 0; j < NDV; j++) begin : g_dv
    for (e = 0; e < 9; e++) begin : g_el
      localparam int LN = 2 - e / 3;
      localparam int SH = NDV - 1 - j;
      logic [DR_W-1:0] dvs;
      logic            ge;
      assign dvs = DR_W'(droot[j][LN]) << SH;
      assign ge  = (dr[j][e] >= dvs);
      always_ff @(posedge clk) begin
        if (adv) begin
          dr[j+1][e] <= ge ? dr[j][e] - dvs : dr[j][e];
          dq[j+1][e] <= {dq[j][e][Q_W-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        droot[j+1] <= droot[j];
        dneg[j+1]  <= dneg[j];
        dst[j+1]   <= dst[j];
      end
    end
  end

  logic [31:0]        mv [9];
  logic signed [31:0] om [9];
  status_t            ost;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mv[i] = ({1'b0, dq[NDV][i]} > ONE_Q30) ? ONE_Q30 : {1'b0, dq[NDV][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        if (dst[NDV] != ST_OK) begin
          om[i] <= '0;
        end else begin
          om[i] <= dneg[NDV][i] ? $signed(-mv[i]) : $signed(mv[i]);
        end
      end
      ost <= dst[NDV];
    end
  end

  assign rsp.m00    = om[0];
  assign rsp.m01    = om[1];
  assign rsp.m02    = om[2];
  assign rsp.m10    = om[3];
  assign rsp.m11    = om[4];
  assign rsp.m12    = om[5];
  assign rsp.m20    = om[6];
  assign rsp.m21    = om[7];
  assign rsp.m22    = om[8];
  assign rsp.status = ost;

endmodule

// ===== design/eofm_chk.sv =====
`include "assert_macros.svh"

module eofm_chk
  import eofm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        rsp_status,
  input logic signed [31:0] m00,
  input logic signed [31:0] m11,
  input logic signed [31:0] m22
);

  `EOFM_ASSERT(a_ready_flow, req_ready == (!rsp_valid || rsp_ready))
  `EOFM_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(m22))
  `EOFM_ASSERT_IMP(a_err_zero, rsp_valid && rsp_status != ST_OK, m00 == 0 && m11 == 0 && m22 == 0)
  `EOFM_ASSERT_IMP(a_no_zero_x, rsp_valid, rsp_status != ST_ZERO_X)
  `EOFM_ASSERT_IMP(a_range, rsp_valid && req_valid, m22 <= ONE_Q30_S && m22 >= -ONE_Q30_S)

endmodule

bind eci_to_orbit_frame_matrix eofm_chk u_eofm_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .m00        (rsp.m00),
  .m11        (rsp.m11),
  .m22        (rsp.m22)
);

// ===== tb/eci_to_orbit_frame_matrix_tb.sv =====
`timescale 1ns / 1ps

module eci_to_orbit_frame_matrix_tb;
  import eofm_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] m[9];
    status_t            stat;
  } frame_t;

  typedef struct {
    logic signed [31:0] p[3];
    logic signed [31:0] v[3];
  } state_vec_t;

  localparam int IDLE_LIMIT = 5000;

  logic clk;
  logic rst;
  int   errors = 0;
  int   idle_cycles = 0;
  int   rsp_cycle = 0;
  frame_t expected_frames[$];

  eofm_req_if req_if();
  eofm_rsp_if rsp_if();

  eci_to_orbit_frame_matrix u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic [255:0] abs_wide(input wide_t a);
    return (a < 0) ? -a : a;
  endfunction

  // floor of the Euclidean length
  function automatic logic [255:0] vec_length(input wide_t a[3]);
    logic [255:0] s;
    logic [255:0] root;
    logic [255:0] bitv;
    logic [255:0] m;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m = abs_wide(a[i]);
      s = s + m * m;
    end
    root = '0;
    bitv = 256'd1 << 254;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] unit_elem(input wide_t c, input logic [255:0] len,
                                                   input bit flip);
    logic [255:0] q;
    logic [31:0]  val;
    bit           neg;
    neg = (c < 0) != flip;
    q = (abs_wide(c) << 30) / len;
    val = (q > ONE_Q30) ? ONE_Q30 : q[31:0];
    return neg ? -val : val;
  endfunction

  function automatic frame_t predict_frame(input state_vec_t sv);
    frame_t       f;
    wide_t        p[3];
    wide_t        v[3];
    wide_t        h[3];
    wide_t        x[3];
    logic [255:0] lz;
    logic [255:0] ly;
    logic [255:0] lx;
    for (int i = 0; i < 9; i++) f.m[i] = '0;
    for (int i = 0; i < 3; i++) begin
      p[i] = sv.p[i];
      v[i] = sv.v[i];
    end
    f.stat = ST_OK;
    lz = vec_length(p);
    if (lz == 0) begin
      f.stat = ST_ZERO_POS;
      return f;
    end
    cross3(p, v, h);
    ly = vec_length(h);
    if (ly == 0) begin
      f.stat = ST_ZERO_MOM;
      return f;
    end
    cross3(h, p, x);
    lx = vec_length(x);
    if (lx == 0) begin
      f.stat = ST_ZERO_X;
      return f;
    end
    for (int i = 0; i < 3; i++) begin
      f.m[i]     = unit_elem(x[i], lx, 1'b0);
      f.m[3 + i] = unit_elem(h[i], ly, 1'b1);
      f.m[6 + i] = unit_elem(p[i], lz, 1'b1);
    end
    return f;
  endfunction

  task automatic send_beat(input state_vec_t sv);
    req_if.valid <= 1'b1;
    req_if.pos_x <= sv.p[0];
    req_if.pos_y <= sv.p[1];
    req_if.pos_z <= sv.p[2];
    req_if.vel_x <= sv.v[0];
    req_if.vel_y <= sv.v[1];
    req_if.vel_z <= sv.v[2];
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_frames.push_back(predict_frame(sv));
  endtask

  task automatic idle_gap(input int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // burst of random length, then a random gap in three of four cases
  int burst_left = 0;
  task automatic send_bursty(input state_vec_t sv);
    send_beat(sv);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 15));
    end
  endtask

  function automatic state_vec_t mk(input int px, input int py, input int pz,
                                    input int vx, input int vy, input int vz);
    state_vec_t sv;
    sv.p[0] = px; sv.p[1] = py; sv.p[2] = pz;
    sv.v[0] = vx; sv.v[1] = vy; sv.v[2] = vz;
    return sv;
  endfunction

  function automatic state_vec_t rand_orbit();
    state_vec_t sv;
    for (int i = 0; i < 3; i++) begin
      sv.p[i] = $signed($urandom_range(0, 1400000000)) - 700000000;
      sv.v[i] = $signed($urandom_range(0, 160000000)) - 80000000;
    end
    return sv;
  endfunction

  function automatic state_vec_t rand_full();
    state_vec_t sv;
    for (int i = 0; i < 3; i++) begin
      sv.p[i] = $urandom();
      sv.v[i] = $urandom();
    end
    return sv;
  endfunction

  function automatic state_vec_t rand_degenerate();
    state_vec_t sv;
    int k;
    sv = rand_full();
    k = $signed($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 3))
      0: begin
        for (int i = 0; i < 3; i++) sv.p[i] = 0;
      end
      1: begin
        for (int i = 0; i < 3; i++) begin
          sv.p[i] = $signed($urandom_range(0, 2000000)) - 1000000;
          sv.v[i] = sv.p[i] * k;
        end
      end
      2: begin
        for (int i = 0; i < 3; i++) sv.v[i] = 0;
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          sv.p[i] = $signed($urandom_range(0, 8)) - 4;
          sv.v[i] = $signed($urandom_range(0, 8)) - 4;
        end
      end
    endcase
    return sv;
  endfunction

  task automatic test_directed();
    int mn;
    int mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_beat(mk(0, 0, 0, 0, 0, 0));
    send_beat(mk(0, 0, 0, mx, mn, 5));
    send_beat(mk(100, 200, 300, 200, 400, 600));
    send_beat(mk(-7, 3, 9, 0, 0, 0));
    send_beat(mk(mn, mn, mn, mn, mn, mn));
    send_beat(mk(mx, mx, mx, mx, mx, mx));
    send_beat(mk(mn, 0, 0, 0, mn, 0));
    send_beat(mk(mx, 0, 0, 0, mx, 0));
    send_beat(mk(mn, mx, mn, mx, mn, mx));
    send_beat(mk(mx, mn, mx, mn, mx, mn));
    send_beat(mk(1, 0, 0, 0, 1, 0));
    send_beat(mk(0, 0, -1, -1, 0, 0));
    send_beat(mk(0, 1, 0, 0, 0, 1));
    send_beat(mk(-1, -1, -1, 1, -1, 0));
    send_beat(mk(mn, mn, mn, 1, 0, 0));
    send_beat(mk(700000000, 0, 0, 0, 75000000, 0));
    send_beat(mk(-1, -1, -1, -1, -1, -1));
    send_beat(mk(mn, 0, 0, mx, 0, 0));
    idle_gap(3);
  endtask

  task automatic test_orbit_random(input int n);
    for (int i = 0; i < n; i++) send_bursty(rand_orbit());
  endtask

  task automatic test_full_random(input int n);
    for (int i = 0; i < n; i++) send_bursty(rand_full());
  endtask

  task automatic test_degenerate_random(input int n);
    for (int i = 0; i < n; i++) send_bursty(rand_degenerate());
  endtask

  task automatic test_drain_pause();
    idle_gap(1);
    while (expected_frames.size() != 0) @(posedge clk);
    for (int i = 0; i < 30; i++) send_beat(rand_orbit());
    idle_gap(1);
  endtask

  // receiver stall pattern, rotating through four styles
  always @(posedge clk) begin
    rsp_cycle <= rsp_cycle + 1;
    case ((rsp_cycle / 400) % 4)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= (rsp_cycle % 7) != 3;
      2: rsp_if.ready <= $urandom_range(0, 2) != 0;
      default: rsp_if.ready <= ((rsp_cycle / 5) % 3) != 0;
    endcase
  end

  always @(posedge clk) begin
    frame_t             want;
    logic signed [31:0] got[9];
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.m00, rsp_if.m01, rsp_if.m02, rsp_if.m10, rsp_if.m11, rsp_if.m12,
              rsp_if.m20, rsp_if.m21, rsp_if.m22};
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected beat, status %0d", $time, rsp_if.status);
        errors++;
      end else begin
        want = expected_frames.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.m[i]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                     want.m[i], got[i]);
            errors++;
          end
        end
        if (rsp_if.status !== want.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, want.stat, rsp_if.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("FAIL eci_to_orbit_frame_matrix");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.pos_x <= '0;
    req_if.pos_y <= '0;
    req_if.pos_z <= '0;
    req_if.vel_x <= '0;
    req_if.vel_y <= '0;
    req_if.vel_z <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_orbit_random(350);
    test_drain_pause();
    test_full_random(250);
    test_degenerate_random(170);
    idle_gap(1);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS eci_to_orbit_frame_matrix");
    end else begin
      $display("FAIL eci_to_orbit_frame_matrix");
    end
    $finish;
  end

endmodule
